[design/mfd_pkg.sv]
package mfd_pkg;

  localparam int LEN_W = 21;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(81920);
  localparam logic [LEN_W-1:0] LEN_SAT         = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_ONE         = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO         = LEN_W'(2);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             frame_start;
    logic             frame_end;
    logic             frame_abort;
    logic [LEN_W-1:0] frame_length;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } mfd_push_t;

endpackage

[design/mfd_core.sv]
module mfd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  mfd_pkg::in_item_t         item,
  input  logic                      cfg_we,
  input  logic [mfd_pkg::LEN_W-1:0] cfg_wdata,
  output mfd_pkg::mfd_push_t        push
);
  import mfd_pkg::*;

  logic             in_frame_r, in_frame_nxt;
  logic             saw_ff_r, saw_ff_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] max_r;
  logic [LEN_W-1:0] len;
  logic             drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      saw_ff_r   <= 1'b0;
      count_r    <= '0;
      max_r      <= MAX_FRAME_RESET;
    end else begin
      if (accept) begin
        in_frame_r <= in_frame_nxt;
        saw_ff_r   <= saw_ff_nxt;
        count_r    <= count_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    len          = (count_r == LEN_SAT) ? count_r : count_r + LEN_ONE;
    drop         = item.stream_end || (max_r <= LEN_TWO);
    in_frame_nxt = in_frame_r;
    saw_ff_nxt   = saw_ff_r;
    count_nxt    = count_r;
    push         = '0;
    push.r0.out_byte     = item.in_byte;
    push.r0.frame_length = len;
    push.r0.run_last     = 1'b1;
    if (!in_frame_r) begin
      if (saw_ff_r && item.in_byte == BYTE_SOI) begin
        push.n                  = 2'd2;
        push.r0.out_byte        = BYTE_FF;
        push.r0.frame_start     = 1'b1;
        push.r0.frame_length    = LEN_ONE;
        push.r0.run_last        = 1'b0;
        push.r1.out_byte        = BYTE_SOI;
        push.r1.frame_abort     = drop;
        push.r1.frame_length    = LEN_TWO;
        push.r1.run_last        = 1'b1;
        in_frame_nxt            = !drop;
        saw_ff_nxt              = 1'b0;
        count_nxt               = drop ? '0 : LEN_TWO;
      end else begin
        saw_ff_nxt = !item.stream_end && (item.in_byte == BYTE_FF);
      end
    end else begin
      push.n = 2'd1;
      if (saw_ff_r && item.in_byte == BYTE_EOI) begin
        push.r0.frame_end = 1'b1;
        in_frame_nxt      = 1'b0;
        saw_ff_nxt        = 1'b0;
        count_nxt         = '0;
      end else if (item.stream_end || len >= max_r || len == LEN_SAT) begin
        push.r0.frame_abort = 1'b1;
        in_frame_nxt        = 1'b0;
        saw_ff_nxt          = 1'b0;
        count_nxt           = '0;
      end else begin
        count_nxt  = len;
        saw_ff_nxt = (item.in_byte == BYTE_FF);
      end
    end
  end

endmodule

[design/mfd_queue.sv]
module mfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  mfd_pkg::mfd_push_t  push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output mfd_pkg::out_item_t  out_data
);
  import mfd_pkg::*;

  out_item_t  mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic [1:0] n_in;
  logic       pop;

  assign n_in      = accept ? push.n : 2'd0;
  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign full      = (count_r > 3'd2);
  assign out_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_in;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      count_r  <= count_r + {1'b0, n_in} - {2'b00, pop};
    end
  end

endmodule

[design/mjpeg_frame_delimiter.sv]
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   in_data   (in_byte, stream_end)
// out       out  out_valid/out_stall out_data  (out_byte, flags, frame_length, run_last)
// cfg       in   cfg_we              cfg_wdata (max_frame_bytes)
//
// One byte per cycle in while in_stall is low; a start marker pushes two items, every frame byte one.
// The result queue holds four items; in_stall rises while more than two wait.
// Results are written into the queue and reach out_data once earlier items have been popped.
// Synchronous active-low reset: hunting, queue empty, limit 81920.
module mjpeg_frame_delimiter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mfd_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mfd_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [mfd_pkg::LEN_W-1:0] cfg_wdata
);
  import mfd_pkg::*;

  mfd_push_t push;
  logic      full;
  logic      accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mfd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push)
  );

  mfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .push     (push),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[design/mfd_checker.sv]
module mfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input mfd_pkg::out_item_t out_data
);
  import mfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  a_start_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_start |->
      out_data.out_byte == BYTE_FF && out_data.frame_length == LEN_ONE && !out_data.run_last)
    else $error("bad frame start item");

  a_start_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.frame_start |=>
      out_valid && out_data.out_byte == BYTE_SOI && out_data.frame_length == LEN_TWO)
    else $error("start marker not followed by 0xD8");

  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |->
      out_data.out_byte == BYTE_EOI && out_data.run_last && !out_data.frame_abort)
    else $error("bad frame end item");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> out_data.frame_start)
    else $error("run_last low outside start marker");

endmodule

bind mjpeg_frame_delimiter mfd_checker u_mfd_checker (.*);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 90;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_we;
  logic [LEN_W-1:0]   cfg_wdata;

  mjpeg_frame_delimiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  in_item_t         stream_q[$];
  out_item_t        frame_bytes_due[$];

  logic             open_frame;
  logic             pend_ff;
  logic [LEN_W-1:0] open_len;
  logic [LEN_W-1:0] len_limit;

  bit  in_taken;
  bit  idle_on;
  bit  hold_req;
  int  hold_left;
  int  quiet;
  int  errs;
  int  n_in;
  int  n_out;
  int  n_ended;
  int  n_aborted;
  int  n_cfg;
  int  frame_items;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_item_t mk_res(logic [7:0] b, logic st, logic en, logic ab,
                                       logic [LEN_W-1:0] len, logic last);
    out_item_t r;
    r.out_byte     = b;
    r.frame_start  = st;
    r.frame_end    = en;
    r.frame_abort  = ab;
    r.frame_length = len;
    r.run_last     = last;
    return r;
  endfunction

  task automatic cut_frame_byte(in_item_t it);
    logic [LEN_W-1:0] len;
    logic             drop;
    if (!open_frame) begin
      if (pend_ff && it.in_byte == BYTE_SOI) begin
        drop = it.stream_end || (len_limit <= LEN_TWO);
        frame_bytes_due.push_back(mk_res(BYTE_FF, 1'b1, 1'b0, 1'b0, LEN_ONE, 1'b0));
        frame_bytes_due.push_back(mk_res(BYTE_SOI, 1'b0, 1'b0, drop, LEN_TWO, 1'b1));
        open_frame = !drop;
        pend_ff    = 1'b0;
        open_len   = drop ? '0 : LEN_TWO;
      end else begin
        pend_ff = !it.stream_end && (it.in_byte == BYTE_FF);
      end
    end else begin
      len = (open_len != LEN_SAT) ? open_len + LEN_ONE : open_len;
      if (pend_ff && it.in_byte == BYTE_EOI) begin
        frame_bytes_due.push_back(mk_res(it.in_byte, 1'b0, 1'b1, 1'b0, len, 1'b1));
        open_frame = 1'b0;
        pend_ff    = 1'b0;
        open_len   = '0;
      end else if (it.stream_end || len >= len_limit || len == LEN_SAT) begin
        frame_bytes_due.push_back(mk_res(it.in_byte, 1'b0, 1'b0, 1'b1, len, 1'b1));
        open_frame = 1'b0;
        pend_ff    = 1'b0;
        open_len   = '0;
      end else begin
        frame_bytes_due.push_back(mk_res(it.in_byte, 1'b0, 1'b0, 1'b0, len, 1'b1));
        open_len = len;
        pend_ff  = (it.in_byte == BYTE_FF);
      end
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t e;
    if (frame_bytes_due.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("result %0d with none due: byte=%h st=%b en=%b ab=%b len=%0d last=%b",
                 n_out, got.out_byte, got.frame_start, got.frame_end, got.frame_abort,
                 got.frame_length, got.run_last);
    end else begin
      e = frame_bytes_due.pop_front();
      if (e.frame_end)
        n_ended++;
      if (e.frame_abort)
        n_aborted++;
      if (got.out_byte !== e.out_byte || got.frame_start !== e.frame_start ||
          got.frame_end !== e.frame_end || got.frame_abort !== e.frame_abort ||
          got.frame_length !== e.frame_length || got.run_last !== e.run_last) begin
        errs++;
        if (errs <= 10) begin
          $display("result %0d exp: byte=%h st=%b en=%b ab=%b len=%0d last=%b",
                   n_out, e.out_byte, e.frame_start, e.frame_end, e.frame_abort,
                   e.frame_length, e.run_last);
          $display("result %0d got: byte=%h st=%b en=%b ab=%b len=%0d last=%b",
                   n_out, got.out_byte, got.frame_start, got.frame_end, got.frame_abort,
                   got.frame_length, got.run_last);
        end
      end
    end
    n_out++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (in_valid && !in_stall) begin
        cut_frame_byte(in_data);
        in_taken = 1'b1;
        n_in++;
        quiet = 0;
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
        quiet = 0;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("[mjpeg_frame_delimiter] ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_valid)) begin
      in_taken = 1'b0;
      if (stream_q.size() != 0 && !(idle_on && $urandom_range(99) < 8)) begin
        in_data  <= stream_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && idle_on && ($urandom_range(99) < 8);
    end
  end

  task automatic push_in(logic [7:0] b, logic se);
    in_item_t it;
    it.in_byte    = b;
    it.stream_end = se;
    stream_q.push_back(it);
  endtask

  function automatic logic rare_end();
    return $urandom_range(49) == 0;
  endfunction

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(9))
      0: return BYTE_FF;
      1: return BYTE_EOI;
      2: return BYTE_SOI;
      3: return 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    len_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic queue_frame(int body_max);
    int n;
    int k;
    n = $urandom_range(body_max);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, rare_end());
    repeat (n) push_in(rnd_byte(), rare_end());
    k = $urandom_range(99);
    if (k < 85) begin
      push_in(BYTE_FF, 1'b0);
      push_in(BYTE_EOI, $urandom_range(9) == 0);
    end else if (k < 95) begin
      push_in(rnd_byte(), 1'b1);
    end
    frame_items += n + 4;
  endtask

  task automatic run_phase(logic [LEN_W-1:0] lim, int body_max, bit squeeze);
    int goal;
    wait_drained();
    write_limit(lim);
    goal = frame_items + PHASE_ITEMS;
    while (frame_items < goal) begin
      if ($urandom_range(9) < 3)
        repeat ($urandom_range(1, 3)) push_in(8'($urandom_range(255)), rare_end());
      queue_frame(body_max);
    end
    if (squeeze) begin
      repeat (20) @(posedge clk);
      hold_req = 1'b1;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_taken   = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    hold_left  = 0;
    open_frame = 1'b0;
    pend_ff    = 1'b0;
    open_len   = '0;
    len_limit  = MAX_FRAME_RESET;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    push_in(8'h00, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b0);
    push_in(8'h00, 1'b0);
    push_in(BYTE_EOI, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(8'h7F, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_EOI, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b0);
    push_in(BYTE_EOI, 1'b0);
    push_in(8'h55, 1'b1);
    push_in(BYTE_FF, 1'b1);
    push_in(BYTE_SOI, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b1);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b0);
    push_in(8'hAA, 1'b0);
    wait_drained();
    write_limit(LEN_TWO);
    push_in(8'hBB, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b0);
    wait_drained();
    write_limit(LEN_W'(4));
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_SOI, 1'b0);
    push_in(BYTE_FF, 1'b0);
    push_in(BYTE_EOI, 1'b0);

    run_phase(LEN_W'(4), 6, 1'b0);
    run_phase(LEN_W'(9), 14, 1'b0);
    run_phase(LEN_W'(23), 30, 1'b0);
    wait_drained();
    idle_on = 1'b0;
    run_phase(LEN_W'(200), 40, 1'b0);
    wait_drained();
    idle_on = 1'b1;
    run_phase(LEN_W'(1048576), 40, 1'b1);
    run_phase(LEN_SAT, 40, 1'b0);
    run_phase(MAX_FRAME_RESET, 20, 1'b0);
    wait_drained();
    repeat (8) @(negedge clk);
    if (frame_bytes_due.size() != 0)
      errs++;

    $display("%0d bytes in, %0d results checked over %0d limit settings",
             n_in, n_out, n_cfg);
    $display("%0d frames closed by end marker, %0d aborted, %0d mismatches",
             n_ended, n_aborted, errs);
    if (errs == 0)
      $display("[mjpeg_frame_delimiter] OK");
    else
      $display("[mjpeg_frame_delimiter] ERROR");
    $finish;
  end

endmodule
